// ----- sv/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the decimal transmit queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  // Queue size default (holds QUEUE_DEPTH-1 bytes)
  localparam int unsigned DefQueueDepth = 64;

  // Number formatting
  localparam int unsigned ValueW    = 31;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam logic [7:0]  AsciiZero = 8'h30;

  // Item kinds
  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindNum   = 2'd1;
  localparam logic [1:0] KindReady = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        byte_in;
    logic [ValueW-1:0] value;
    logic              two_digit;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_enabled;
    logic       dropped;
  } out_t;

endpackage

// ----- sv/decimal_tx_queue.sv -----
// ----------------------------------------------------------------------------
// decimal_tx_queue
// Transmit ring queue with a decimal formatter and interrupt-enable mark.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid_i, in_ready_o, in_i     | item: byte, number or tx-ready
//  out     | out_valid_o, out_ready_i, out_o  | one result per item
//
// Byte push and ready event: accept leads straight to the done state (the ring
// memory read is registered at accept). Number push: converter (one bit per
// cycle in dtq_bcd), one queue write per digit (1..10), then the done state.
// One item is worked on at a time; the output register lets the next item
// enter while a result waits. No clearing pass: the memory is used as is.
// A stalled result holds only the finished item; the next one waits in the
// done state until the output register frees.
// ----------------------------------------------------------------------------
module decimal_tx_queue
  import dtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_PUSH, S_DONE} state_e;

  state_e          state_q;
  logic [AW-1:0]   wr_q, rd_q, wr_next, rd_next;
  logic            mark_q, drop_q, txv_q, two_q;
  logic [BcdW-1:0] dig_q;
  logic [3:0]      cnt_q;
  logic [7:0]      rdata_q;
  logic            out_valid_q;
  out_t            out_q;
  logic [7:0]      mem [QUEUE_DEPTH];

  logic            in_fire, conv_done, enq_en, full, pop_en;
  logic [7:0]      enq_byte;
  logic [BcdW-1:0] bcd;
  logic [3:0]      lead;
  logic [5:0]      shamt;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // Ring index advance with wrap at any depth
  assign wr_next = (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
  assign rd_next = (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
  assign full    = (wr_next == rd_q);

  // Converter
  dtq_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && (in_i.kind == KindNum)),
    .value_i (in_i.value),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  // Most significant nonzero digit (zero gives digit 0)
  always_comb begin
    lead = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) lead = 4'(i);
    end
    shamt = 6'(4 * (NumDigits - 1)) - {lead, 2'b00};
  end

  // Queue write and pop requests
  always_comb begin
    enq_en   = 1'b0;
    enq_byte = in_i.byte_in;
    if (in_fire && (in_i.kind == KindByte)) begin
      enq_en = 1'b1;
    end else if (state_q == S_PUSH) begin
      enq_en   = 1'b1;
      enq_byte = AsciiZero + {4'd0, dig_q[BcdW-1 -: 4]};
    end
  end
  assign pop_en = in_fire && (in_i.kind == KindReady) && mark_q && (wr_q != rd_q);

  // Ring memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (enq_en && !full) mem[wr_q] <= enq_byte;
    if (pop_en)          rdata_q   <= mem[rd_q];
  end

  // Sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_q        <= '0;
      rd_q        <= '0;
      mark_q      <= 1'b0;
      drop_q      <= 1'b0;
      txv_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      if (enq_en) begin
        mark_q <= 1'b1;
        if (full) drop_q <= 1'b1;
        else      wr_q   <= wr_next;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            drop_q <= 1'b0;
            txv_q  <= 1'b0;
            two_q  <= in_i.two_digit;
            if (in_i.kind == KindByte) begin
              drop_q  <= full;
              state_q <= S_DONE;
            end else if (in_i.kind == KindNum) begin
              state_q <= S_CONV;
            end else begin
              if (in_i.kind == KindReady && mark_q) begin
                if (wr_q == rd_q) begin
                  mark_q <= 1'b0;
                end else begin
                  rd_q  <= rd_next;
                  txv_q <= 1'b1;
                end
              end
              state_q <= S_DONE;
            end
          end
        end
        S_CONV: begin
          if (conv_done) begin
            if (two_q) begin
              dig_q <= {bcd[7:0], {(BcdW-8){1'b0}}};
              cnt_q <= 4'd2;
            end else begin
              dig_q <= bcd << shamt;
              cnt_q <= lead + 4'd1;
            end
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          dig_q <= {dig_q[BcdW-5:0], 4'd0};
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd1) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.tx_valid    <= txv_q;
            out_q.tx_byte     <= txv_q ? rdata_q : 8'd0;
            out_q.irq_enabled <= mark_q;
            out_q.dropped     <= drop_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks
  a_tx_needs_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.tx_valid |-> out_o.irq_enabled)
    else $error("byte sent with interrupt mark clear");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.tx_valid |-> out_o.tx_byte == 8'd0)
    else $error("tx_byte nonzero without a sent byte");

  a_conv_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> state_q == S_CONV)
    else $error("converter finished outside conversion");

  a_pop_moves_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_en |=> rd_q != $past(rd_q))
    else $error("pop did not advance read index");

endmodule

// ----- sv/dtq_bcd.sv -----
// ----------------------------------------------------------------------------
// dtq_bcd
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ----------------------------------------------------------------------------
module dtq_bcd
  import dtq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  output logic              done_o,
  output logic [BcdW-1:0]   bcd_o
);

  localparam int unsigned CntW = $clog2(ValueW);

  logic [ValueW-1:0] bin_q;
  logic [BcdW-1:0]   bcd_q, adj;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                 : bcd_q[4*i +: 4];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(ValueW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[ValueW-2:0], 1'b0};
      bcd_q <= {adj[BcdW-2:0], bin_q[ValueW-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for decimal_tx_queue: a directed table walks the empty,
// full and formatting corner cases, then random byte pushes, number pushes and
// transmitter-ready events run in push-heavy and drain-heavy segments. Every
// result is checked against an in-bench model of the ring queue or a table row.
// ----------------------------------------------------------------------------
module tb;
  import dtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDepth     = DefQueueDepth;
  localparam int unsigned Radix      = 10;
  localparam logic [1:0]  KindUnused = 2'd3;
  localparam int          RandItems  = 826;
  localparam int          QuietTail  = 100;
  localparam int          HoldAtRes  = 300;   // result count that starts the long stall
  localparam int          HoldCycles = 300;
  localparam int          IdleLimit  = 4000;  // cycles without any transaction
  localparam int          DrainWait  = 60;
  localparam int          MaxReports = 10;

  typedef struct {
    in_t  stim;
    bit   has_exp;
    out_t exp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Queue model state
  logic [7:0]        ring_mem [QDepth];
  int unsigned       ring_wr;
  int unsigned       ring_rd;
  logic              irq_mark;

  out_t              pending_tx_q[$];
  dir_row_t          dir_tab[$];

  int                mismatches;
  int                items_sent;
  int                results_seen;
  int                bytes_tx;
  int                drops_seen;
  int                input_stalls;
  bit                quiet;
  bit                stim_done;

  decimal_tx_queue #(
    .QUEUE_DEPTH(QDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Ring queue model
  function automatic logic push_ring(input logic [7:0] b);
    int unsigned nxt;
    nxt = (ring_wr + 1 >= QDepth) ? 0 : ring_wr + 1;
    irq_mark = 1'b1;
    if (nxt == ring_rd) return 1'b1;
    ring_mem[ring_wr] = b;
    ring_wr = nxt;
    return 1'b0;
  endfunction

  function automatic out_t predict_tx(input in_t it);
    out_t            r;
    logic            drop;
    longint unsigned v;
    longint unsigned div;
    int              ndig;
    r    = '0;
    drop = 1'b0;
    case (it.kind)
      KindByte: drop = push_ring(it.byte_in);
      KindNum: begin
        v   = it.value;
        div = 1;
        if (it.two_digit) begin
          div = Radix;
        end else begin
          ndig = 1;
          while (ndig < NumDigits && div * Radix <= v) begin
            div *= Radix;
            ndig++;
          end
        end
        while (div > 0) begin
          drop |= push_ring(AsciiZero + 8'((v / div) % Radix));
          div /= Radix;
        end
      end
      KindReady: begin
        if (irq_mark) begin
          if (ring_wr == ring_rd) begin
            irq_mark = 1'b0;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte  = ring_mem[ring_rd];
            ring_rd    = (ring_rd + 1 >= QDepth) ? 0 : ring_rd + 1;
          end
        end
      end
      default: ;
    endcase
    r.irq_enabled = irq_mark;
    r.dropped     = drop;
    return r;
  endfunction

  function automatic out_t res(input logic v, input logic [7:0] b,
                               input logic irq, input logic drop);
    out_t r;
    r.tx_valid    = v;
    r.tx_byte     = b;
    r.irq_enabled = irq;
    r.dropped     = drop;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [7:0] b,
                                  input logic [ValueW-1:0] v, input logic two,
                                  input bit has_exp, input out_t exp);
    dir_row_t row;
    row.stim.kind      = kind;
    row.stim.byte_in   = b;
    row.stim.value     = v;
    row.stim.two_digit = two;
    row.has_exp        = has_exp;
    row.exp            = exp;
    dir_tab.push_back(row);
  endfunction

  // Random item: push_pct sets how push-heavy the current segment is
  function automatic in_t rand_item(input int push_pct);
    in_t             it;
    int              r;
    int              k;
    longint unsigned p;
    it.byte_in   = 8'($urandom);
    it.value     = ValueW'($urandom);
    it.two_digit = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      it.kind = $urandom_range(0, 1) ? KindNum : KindByte;
      if (it.kind == KindNum) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: it.value = ValueW'($urandom_range(0, 99));
          4, 5, 6: begin
            k = $urandom_range(0, 9);
            p = 1;
            repeat (k) p *= Radix;
            if (k > 0 && $urandom_range(0, 1)) p -= 1;
            it.value = ValueW'(p);
          end
          default: ;
        endcase
      end
    end else if (r < 97) begin
      it.kind = KindReady;
    end else begin
      it.kind = KindUnused;
    end
    return it;
  endfunction

  // Present one transaction and record its expected result on acceptance
  task automatic offer(input in_t it, input bit has_exp, input out_t exp);
    out_t r;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready) begin
      input_stalls++;
      @(posedge clk_i);
    end
    r = predict_tx(it);
    if (has_exp) r = exp;
    pending_tx_q.push_back(r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  // Stimulus
  initial begin
    in_t     it;
    int      n_rand;
    int      seg_left;
    int      push_pct;
    out_t    none;
    in_valid   = 1'b0;
    in_data    = '0;
    ring_wr    = 0;
    ring_rd    = 0;
    irq_mark   = 1'b0;
    mismatches = 0;
    items_sent = 0;
    quiet      = 1'b0;
    stim_done  = 1'b0;
    none       = '0;

    // Directed corners: idle mark, drain to empty, formatting, filling up
    add_row(KindReady,  8'h00, '0,           1'b0, 1, res(0, 8'h00, 0, 0));
    add_row(KindUnused, 8'hff, '1,           1'b1, 1, res(0, 8'h00, 0, 0));
    add_row(KindByte,   8'h00, '0,           1'b0, 1, res(0, 8'h00, 1, 0));
    add_row(KindByte,   8'hff, '1,           1'b1, 1, res(0, 8'h00, 1, 0));
    add_row(KindReady,  8'h00, '0,           1'b0, 1, res(1, 8'h00, 1, 0));
    add_row(KindReady,  8'h00, '0,           1'b0, 1, res(1, 8'hff, 1, 0));
    add_row(KindReady,  8'h00, '0,           1'b0, 1, res(0, 8'h00, 0, 0));
    add_row(KindReady,  8'hff, '1,           1'b1, 1, res(0, 8'h00, 0, 0));
    add_row(KindNum,    8'h00, '0,           1'b0, 1, res(0, 8'h00, 1, 0));
    add_row(KindNum,    8'h00, '0,           1'b1, 1, res(0, 8'h00, 1, 0));
    add_row(KindNum,    8'h00, '1,           1'b0, 0, none);
    add_row(KindNum,    8'hff, '1,           1'b1, 0, none);
    add_row(KindNum,    8'ha5, 31'd9,        1'b0, 0, none);
    add_row(KindUnused, 8'h5a, '1,           1'b0, 0, none);
    add_row(KindNum,    8'h00, 31'd1000000000, 1'b0, 0, none);
    add_row(KindNum,    8'h00, 31'd1234567890, 1'b0, 0, none);
    add_row(KindNum,    8'h00, 31'd1999999999, 1'b0, 0, none);
    add_row(KindNum,    8'h00, 31'd1000000000, 1'b0, 0, none);
    add_row(KindNum,    8'h00, 31'd1234567890, 1'b0, 0, none);
    add_row(KindNum,    8'h00, 31'd2000000001, 1'b0, 0, none);
    add_row(KindByte,   8'h5a, '0,           1'b0, 1, res(0, 8'h00, 1, 1));
    add_row(KindReady,  8'h00, '0,           1'b0, 0, none);
    add_row(KindByte,   8'h80, '0,           1'b1, 0, none);
    add_row(KindByte,   8'h7f, '0,           1'b0, 1, res(0, 8'h00, 1, 1));

    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (dir_tab[i]) begin
      maybe_gap();
      offer(dir_tab[i].stim, dir_tab[i].has_exp, dir_tab[i].exp);
    end

    // Random segments pick a push-heavy, balanced or drain-heavy mix of items
    n_rand   = 0;
    seg_left = 0;
    push_pct = 50;
    while (n_rand < RandItems) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      seg_left--;
      it = rand_item(push_pct);
      if (it.kind != KindUnused) n_rand++;
      if (n_rand >= RandItems - QuietTail) quiet = 1'b1;
      maybe_gap();
      offer(it, 0, none);
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;

    // Drain, then allow a number conversion's worth of extra cycles
    while (pending_tx_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d transactions (%0d results): %0d bytes sent, %0d full-queue drops,",
             items_sent, results_seen, bytes_tx, drops_seen);
    $display("%0d cycles of input backpressure, including one long receiver stall.",
             input_stalls);
    if (mismatches == 0 && pending_tx_q.size() == 0) begin
      $display("decimal_tx_queue test passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, pending_tx_q.size());
      $display("decimal_tx_queue test failed");
    end
    $finish;
  end

  // Result side: random not-ready gaps plus one long hold-off
  initial begin
    out_t exp;
    bit   rdy;
    bit   held;
    int   hold_left;
    int   burst_left;
    out_ready    = 1'b0;
    results_seen = 0;
    bytes_tx     = 0;
    drops_seen   = 0;
    held         = 1'b0;
    hold_left    = 0;
    burst_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held && results_seen >= HoldAtRes) begin
        held      = 1'b1;
        hold_left = HoldCycles - 1;
        rdy       = 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(1, 3) - 1;
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
      @(posedge clk_i);
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.tx_valid) bytes_tx++;
        if (out_data.dropped) drops_seen++;
        if (pending_tx_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result with no transaction pending: valid=%0b byte=%02h irq=%0b drop=%0b",
                     out_data.tx_valid, out_data.tx_byte, out_data.irq_enabled,
                     out_data.dropped);
        end else begin
          exp = pending_tx_q.pop_front();
          if (out_data.tx_valid !== exp.tx_valid || out_data.tx_byte !== exp.tx_byte ||
              out_data.irq_enabled !== exp.irq_enabled || out_data.dropped !== exp.dropped)
          begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("result %0d mismatch: exp valid=%0b byte=%02h irq=%0b drop=%0b, got %s",
                       results_seen, exp.tx_valid, exp.tx_byte, exp.irq_enabled,
                       exp.dropped,
                       $sformatf("valid=%0b byte=%02h irq=%0b drop=%0b", out_data.tx_valid,
                                 out_data.tx_byte, out_data.irq_enabled, out_data.dropped));
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else if (!stim_done || pending_tx_q.size() != 0) idle_cycles++;
    end
    $display("timeout after %0d idle cycles, %0d results outstanding", idle_cycles,
             pending_tx_q.size());
    $display("decimal_tx_queue test failed");
    $finish;
  end

endmodule
